@@ sv/erfw_pkg.sv @@
// Shared types and constants of the Winitzki erf approximation unit.
package erfw_pkg;

   // Fixed-point constants of the approximation.
   localparam logic [21:0] ALPHA_Q24  = 22'd2466251;
   localparam logic [24:0] FOURPI_Q24 = 25'd21361415;
   localparam logic [24:0] ONE_Q24    = 25'd16777216;
   localparam logic [31:0] ONE_Q31    = 32'h8000_0000;
   localparam logic [32:0] EXP_CUTOFF = 33'h0_2000_0000;
   localparam logic [32:0] ROUND_Q24  = 33'h0_0080_0000;
   localparam logic [63:0] ROUND_Q31  = 64'h0000_0000_4000_0000;
   localparam logic [16:0] MAG_MAX    = 17'd32767;

   // Pipeline depths.
   localparam int DIV_STAGES  = 25;
   localparam int SERIES_LEN  = 12;
   localparam int SQUARINGS   = 6;
   localparam int SQRT_STAGES = 32;
   localparam int EXP_LAT     = SERIES_LEN * 3 + 1 + SQUARINGS;
   localparam int PIPE_LAT    = 3 + DIV_STAGES + 2 + EXP_LAT + SQRT_STAGES + 1;

   // One stage of the restoring divider.
   typedef struct packed {
      logic [27:0] rem;
      logic [24:0] low;
      logic [24:0] quo;
      logic [27:0] den;
   } div_stage_type;

   // One stage of the exponential series.
   typedef struct packed {
      logic        zero;
      logic [29:0] u;
      logic [31:0] term;
      logic [30:0] prod;
      logic [32:0] pos;
      logic [32:0] neg;
   } exp_stage_type;

   // Reciprocal floor(2^33 / n) for the small constant divisors of the series.
   function automatic logic [33:0] recip_q33(input logic [3:0] n);
      logic [33:0] r;
      unique case (n)
         4'd1:    r = 34'd8589934592;
         4'd2:    r = 34'd4294967296;
         4'd3:    r = 34'd2863311530;
         4'd4:    r = 34'd2147483648;
         4'd5:    r = 34'd1717986918;
         4'd6:    r = 34'd1431655765;
         4'd7:    r = 34'd1227133513;
         4'd8:    r = 34'd1073741824;
         4'd9:    r = 34'd954437176;
         4'd10:   r = 34'd858993459;
         4'd11:   r = 34'd780903144;
         4'd12:   r = 34'd715827882;
         default: r = 34'd0;
      endcase
      return r;
   endfunction

endpackage

@@ sv/erf_winitzki_approx_unit.sv @@
// Top level of the Winitzki erf approximation unit.
//
//  channel | direction | ports                            | payload
//  req     | in        | req_valid, req_stall, req_x_value | x, signed Q3.12
//  rsp     | out       | rsp_valid, rsp_stall, rsp_erf_value | erf(x), signed Q1.15
//
// One item can enter per cycle unless the pipeline is held.
// Depth: three front stages, a 25-stage divider, two stages for t, a 43-stage
// exponential (three stages per series term, the sum and six squarings), a 32-stage
// square root and the output register, 106 register stages in all.
// The whole pipeline holds while a result waits with rsp_stall high.
// Reset clears the valid bits only; the unit keeps no other state.
module erf_winitzki_approx_unit import erfw_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_x_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_erf_value
);

   logic        adv;
   logic        vld_ff [PIPE_LAT];
   logic        neg_ff [PIPE_LAT];

   // Pipeline advances unless the finished item is held.
   assign adv       = ~(vld_ff[PIPE_LAT-1] & rsp_stall);
   assign req_stall = ~adv;
   assign rsp_valid = vld_ff[PIPE_LAT-1];

   // Valid and sign bits travel with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PIPE_LAT; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (adv) begin
         vld_ff[0] <= req_valid;
         for (int i = 1; i < PIPE_LAT; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         neg_ff[0] <= req_x_value[15];
         for (int i = 1; i < PIPE_LAT; i++) begin
            neg_ff[i] <= neg_ff[i-1];
         end
      end
   end

   // Magnitude and its square.
   logic [16:0] mag_x;
   logic [33:0] xsq_full;
   logic [30:0] xsq1_ff;
   always_comb begin
      mag_x    = req_x_value[15] ? (17'h10000 - {1'b0, req_x_value}) : {1'b0, req_x_value};
      xsq_full = mag_x * mag_x;
   end

   // Scaled square z = 0.147 x^2, then numerator and denominator.
   logic [52:0] z_full;
   logic [27:0] z_ff;
   logic [30:0] xsq2_ff;
   logic [27:0] num_ff;
   logic [27:0] den_ff;
   logic [30:0] xsq3_ff;
   assign z_full = ALPHA_Q24 * xsq1_ff + 53'(ROUND_Q24);

   always_ff @(posedge clock) begin
      if (adv) begin
         xsq1_ff <= xsq_full[30:0];
         z_ff    <= z_full[51:24];
         xsq2_ff <= xsq1_ff;
         num_ff  <= 28'(FOURPI_Q24) + z_ff;
         den_ff  <= 28'(ONE_Q24) + z_ff;
         xsq3_ff <= xsq2_ff;
      end
   end

   // Rational factor r = num / den.
   logic [24:0] rat;
   logic [30:0] xsq_dly_ff [DIV_STAGES];

   erfw_div u_div (
      .clock   (clock),
      .adv     (adv),
      .num_in  (num_ff),
      .den_in  (den_ff),
      .quo_out (rat)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         xsq_dly_ff[0] <= xsq3_ff;
         for (int i = 1; i < DIV_STAGES; i++) begin
            xsq_dly_ff[i] <= xsq_dly_ff[i-1];
         end
      end
   end

   // Exponent argument t = r x^2, and its scaled form u = t/64 in Q.31.
   logic [56:0] t_full;
   logic [32:0] t_ff;
   logic [29:0] u_ff;
   logic        zero_ff;
   assign t_full = rat * xsq_dly_ff[DIV_STAGES-1] + 57'(ROUND_Q24);

   always_ff @(posedge clock) begin
      if (adv) begin
         t_ff    <= t_full[56:24];
         u_ff    <= {t_ff[28:0], 1'b0};
         zero_ff <= (t_ff >= EXP_CUTOFF);
      end
   end

   // exp(-t) and the square root of 1 - exp(-t).
   logic [31:0] e_val;
   logic [31:0] d_val;
   logic [31:0] root;

   erfw_exp u_exp (
      .clock   (clock),
      .adv     (adv),
      .u_in    (u_ff),
      .zero_in (zero_ff),
      .e_out   (e_val)
   );

   assign d_val = ONE_Q31 - e_val;

   erfw_sqrt u_sqrt (
      .clock    (clock),
      .adv      (adv),
      .v_in     ({d_val, 31'd0}),
      .root_out (root)
   );

   // Round to Q1.15, saturate and apply the sign.
   logic [32:0] rnd;
   logic [16:0] mag;
   logic [15:0] mag_sat;
   logic [15:0] erf_ff;
   always_comb begin
      rnd     = {1'b0, root} + 33'h0_0000_8000;
      mag     = rnd[32:16];
      mag_sat = (mag > MAG_MAX) ? MAG_MAX[15:0] : mag[15:0];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         erf_ff <= neg_ff[PIPE_LAT-2] ? (16'd0 - mag_sat) : mag_sat;
      end
   end

   assign rsp_erf_value = erf_ff;

endmodule

@@ sv/erfw_div.sv @@
// Pipelined restoring divider that forms the rational factor in Q.24.
module erfw_div import erfw_pkg::*; (
   input  logic        clock,
   input  logic        adv,
   input  logic [27:0] num_in,
   input  logic [27:0] den_in,
   output logic [24:0] quo_out
);

   div_stage_type st_ff [DIV_STAGES];

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
      div_stage_type src, st_in;
      logic [52:0]   dividend;
      logic [28:0]   r2;
      logic [28:0]   diff;

      // The first stage takes the rounded dividend; the quotient fits 25 bits.
      always_comb begin
         dividend = {num_in, 25'd0} >> 1;
         dividend = {1'b0, num_in, 24'd0} + 53'(den_in >> 1);
         if (k == 0) begin
            src.rem = dividend[52:25];
            src.low = dividend[24:0];
            src.quo = '0;
            src.den = den_in;
         end else begin
            src = st_ff[(k == 0) ? 0 : k - 1];
         end
         r2    = {src.rem, src.low[24]};
         diff  = r2 - {1'b0, src.den};
         st_in = src;
         st_in.low = {src.low[23:0], 1'b0};
         if (r2 >= {1'b0, src.den}) begin
            st_in.rem = diff[27:0];
            st_in.quo = {src.quo[23:0], 1'b1};
         end else begin
            st_in.rem = r2[27:0];
            st_in.quo = {src.quo[23:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            st_ff[k] <= st_in;
         end
      end
   end

   assign quo_out = st_ff[DIV_STAGES-1].quo;

endmodule

@@ sv/erfw_exp.sv @@
// Pipelined exp(-t) in Q.31: Taylor series of exp(-t/64), then six squarings.
module erfw_exp import erfw_pkg::*; (
   input  logic        clock,
   input  logic        adv,
   input  logic [29:0] u_in,
   input  logic        zero_in,
   output logic [31:0] e_out
);

   exp_stage_type a_ff [SERIES_LEN];
   exp_stage_type b_ff [SERIES_LEN];
   exp_stage_type c_ff [SERIES_LEN];
   logic [31:0]   f_ff;
   logic [31:0]   sq_ff [SQUARINGS];

   // Each term takes three stages: multiply by u, reciprocal multiply, correct.
   for (genvar j = 0; j < SERIES_LEN; j++) begin : g_term
      localparam logic [3:0]  N = 4'(j + 1);
      localparam logic [33:0] R = recip_q33(N);
      exp_stage_type src, a_in, b_in, c_in;
      logic [61:0]   prod_a;
      logic [64:0]   prod_b;
      logic [31:0]   rem_c;
      logic [31:0]   term_c;

      always_comb begin
         if (j == 0) begin
            src.zero = zero_in;
            src.u    = u_in;
            src.term = ONE_Q31;
            src.prod = '0;
            src.pos  = {1'b0, ONE_Q31};
            src.neg  = '0;
         end else begin
            src = c_ff[(j == 0) ? 0 : j - 1];
         end
         prod_a = src.term * src.u;
         a_in = src;
         a_in.prod = prod_a[61:31];

         prod_b = a_ff[j].prod * R;
         b_in = a_ff[j];
         b_in.term = prod_b[64:33];

         // The estimate is the quotient or one less.
         rem_c  = {1'b0, b_ff[j].prod} - b_ff[j].term * {28'd0, N};
         term_c = (rem_c >= {28'd0, N}) ? b_ff[j].term + 32'd1 : b_ff[j].term;
         c_in = b_ff[j];
         c_in.term = term_c;
         if (N[0]) begin
            c_in.neg = b_ff[j].neg + {1'b0, term_c};
         end else begin
            c_in.pos = b_ff[j].pos + {1'b0, term_c};
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            a_ff[j] <= a_in;
            b_ff[j] <= b_in;
            c_ff[j] <= c_in;
         end
      end
   end

   // Series sum clamped to [0, 1.0]; a large argument gives zero.
   logic [32:0] sum;
   logic [31:0] f_in;
   always_comb begin
      sum = c_ff[SERIES_LEN-1].pos - c_ff[SERIES_LEN-1].neg;
      if (c_ff[SERIES_LEN-1].zero || (c_ff[SERIES_LEN-1].pos <= c_ff[SERIES_LEN-1].neg)) begin
         f_in = '0;
      end else if (sum > {1'b0, ONE_Q31}) begin
         f_in = ONE_Q31;
      end else begin
         f_in = sum[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f_ff <= f_in;
      end
   end

   // Repeated rounded squaring undoes the scaling by 1/64.
   for (genvar k = 0; k < SQUARINGS; k++) begin : g_square
      logic [31:0] src;
      logic [63:0] prod;
      logic [64:0] rnd;
      logic [31:0] sq_in;

      always_comb begin
         src  = (k == 0) ? f_ff : sq_ff[(k == 0) ? 0 : k - 1];
         prod = src * src;
         rnd  = {1'b0, prod} + {1'b0, ROUND_Q31};
         sq_in = (rnd[64:31] > {2'b00, ONE_Q31}) ? ONE_Q31 : rnd[62:31];
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            sq_ff[k] <= sq_in;
         end
      end
   end

   assign e_out = sq_ff[SQUARINGS-1];

endmodule

@@ sv/erfw_sqrt.sv @@
// Pipelined integer square root, one result bit per stage.
module erfw_sqrt import erfw_pkg::*; (
   input  logic        clock,
   input  logic        adv,
   input  logic [62:0] v_in,
   output logic [31:0] root_out
);

   logic [62:0] v_ff    [SQRT_STAGES];
   logic [63:0] root_ff [SQRT_STAGES];

   for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
      localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
      logic [62:0] v_src;
      logic [63:0] r_src;
      logic [63:0] cand;
      logic [63:0] v_left;
      logic [62:0] v_next;
      logic [63:0] r_next;

      // Subtract root plus bit where it fits and set the bit in the root.
      always_comb begin
         if (k == 0) begin
            v_src = v_in;
            r_src = '0;
         end else begin
            v_src = v_ff[(k == 0) ? 0 : k - 1];
            r_src = root_ff[(k == 0) ? 0 : k - 1];
         end
         cand   = r_src + BIT;
         v_left = {1'b0, v_src} - cand;
         if ({1'b0, v_src} >= cand) begin
            v_next = v_left[62:0];
            r_next = (r_src >> 1) + BIT;
         end else begin
            v_next = v_src;
            r_next = r_src >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            v_ff[k]    <= v_next;
            root_ff[k] <= r_next;
         end
      end
   end

   assign root_out = root_ff[SQRT_STAGES-1][31:0];

endmodule

@@ test/erf_checker.sv @@
// Checker of the erf approximation unit: predicts each result and compares it.
`timescale 1ns / 100ps
module erf_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [15:0] req_x_value,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [15:0] rsp_erf_value,
   output int          fail_count,
   output int          pending_count,
   output int          result_count
);

   logic [15:0] erf_expected_q[$];

   // Negated exponential exp(-t) in Q.31 for t in Q.24.
   function automatic logic [63:0] neg_exp_q31(input logic [63:0] t);
      logic [63:0] u, term, pos, neg, e;
      if (t >= 64'd536870912) return 64'd0;
      u = t << 1;
      term = 64'd2147483648;
      pos = term;
      neg = 64'd0;
      for (int n = 1; n <= 12; n++) begin
         term = ((term * u) >> 31) / n;
         if (n % 2 == 1) neg += term;
         else pos += term;
      end
      e = (pos > neg) ? pos - neg : 64'd0;
      if (e > 64'd2147483648) e = 64'd2147483648;
      for (int k = 0; k < 6; k++) begin
         e = (e * e + 64'd1073741824) >> 31;
         if (e > 64'd2147483648) e = 64'd2147483648;
      end
      return e;
   endfunction

   // Integer square root, bit by bit.
   function automatic logic [63:0] int_sqrt(input logic [63:0] v);
      logic [63:0] root, bitv;
      root = 64'd0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= root + bitv) begin
            v -= root + bitv;
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      return root;
   endfunction

   // Winitzki approximation of erf(x) for x in Q3.12.
   function automatic logic [15:0] predict_erf(input logic [15:0] x);
      logic [63:0] m, xsq, z, num, den, rat, t, d, s, mag;
      logic        negative;
      negative = x[15];
      m = negative ? (64'h10000 - x) : {48'd0, x};
      xsq = m * m;
      z = (64'd2466251 * xsq + 64'd8388608) >> 24;
      num = 64'd21361415 + z;
      den = 64'd16777216 + z;
      rat = ((num << 24) + (den >> 1)) / den;
      t = (rat * xsq + 64'd8388608) >> 24;
      d = 64'd2147483648 - neg_exp_q31(t);
      s = int_sqrt(d << 31);
      mag = (s + 64'd32768) >> 16;
      if (mag > 64'd32767) mag = 64'd32767;
      return negative ? 16'(64'h10000 - mag) : mag[15:0];
   endfunction

   assign pending_count = erf_expected_q.size();

   // Record each accepted argument and check each accepted result.
   always @(posedge clock) begin
      logic [15:0] want;
      if (reset) begin
         fail_count <= 0;
         result_count <= 0;
      end else begin
         if (req_valid && !req_stall) erf_expected_q.push_back(predict_erf(req_x_value));
         if (rsp_valid && !rsp_stall) begin
            result_count <= result_count + 1;
            if (erf_expected_q.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %0d",
                        $time, $signed(rsp_erf_value));
               fail_count <= fail_count + 1;
            end else begin
               want = erf_expected_q.pop_front();
               if (want !== rsp_erf_value) begin
                  $display("%0t: erf_value mismatch, expected %0d, actual %0d",
                           $time, $signed(want), $signed(rsp_erf_value));
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

@@ test/testbench.sv @@
// Top of the testbench: clock, reset, argument stimulus and verdict.
`timescale 1ns / 100ps
module testbench;

   localparam int RANDOM_ITEMS = 750;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int LATENCY      = 106;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [15:0] req_x_value = 16'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b1;
   logic [15:0] rsp_erf_value;
   int          fail_count, pending_count, result_count;
   int          cycle_count = 0;
   int          sent_count = 0;
   bit          calm_phase = 1'b0;
   bit          hold_done = 1'b0;
   bit          hold_start = 1'b0;

   erf_winitzki_approx_unit u_dut (.*);

   erf_checker u_checker (.*);

   always #6 clock = ~clock;

   // Cycle count and timeout.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles.", cycle_count);
         $display("FAIL erf_winitzki_approx_unit");
         $finish;
      end
   end

   // Receiver: random stall bursts, one long hold-off, none at the end.
   initial begin
      int burst;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_start && !hold_done) begin
            rsp_stall <= 1'b1;
            repeat (400) @(posedge clock);
            hold_done = 1'b1;
         end else if (!calm_phase && $urandom_range(0, 2) == 0) begin
            burst = $urandom_range(1, 11);
            rsp_stall <= 1'b1;
            repeat (burst) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   // Offer one argument and wait until it is accepted.
   task automatic send_arg(input logic [15:0] x, input bit may_idle);
      if (may_idle && !calm_phase && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_x_value <= x;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_count++;
   endtask

   // Random argument, mostly in the interesting range of the curve.
   function automatic logic [15:0] random_arg();
      case ($urandom_range(0, 3))
         0: return 16'($urandom);
         1: return 16'($signed($urandom_range(0, 16384)) - 8192);
         2: return 16'($signed($urandom_range(0, 2048)) - 1024);
         default: return 16'($signed($urandom_range(0, 24576)) - 12288);
      endcase
   endfunction

   initial begin
      logic [15:0] directed[$] = '{16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000,
                                   16'h8001, 16'h1000, 16'hF000, 16'h2000, 16'hE000,
                                   16'h0800, 16'hF800, 16'h3000, 16'h4000, 16'hC000,
                                   16'h5555, 16'hAAAA, 16'h0010, 16'hFFF0};
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed[i]) send_arg(directed[i], 1'b1);
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == 200) hold_start = 1'b1;
         if (i == RANDOM_ITEMS - 150) calm_phase = 1'b1;
         send_arg(random_arg(), !(hold_start && !hold_done));
      end
      req_valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (LATENCY + 20) @(posedge clock);
      $display("Sent %0d arguments over [-8, 8), including extremes and zero.", sent_count);
      $display("Checked %0d results under random stalls and one long hold-off.",
               result_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("PASS erf_winitzki_approx_unit");
      end else begin
         $display("FAIL erf_winitzki_approx_unit");
      end
      $finish;
   end

endmodule
